// ===== sv/dles_pkg.sv =====
// Package for the double-ended list store: sizes, codes and word types
`timescale 1ns / 1ps
`default_nettype none

package dles_pkg;

  // storage size; field widths of the words below are fixed at this size
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned DATA_W   = 32;

  // operation codes carried by an input word
  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_INSERT     = 4'd4,
    OP_ERASE      = 4'd5,
    OP_READ       = 4'd6,
    OP_REVERSE    = 4'd7,
    OP_CLEAR      = 4'd8
  } op_e;

  // status codes of a result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // what the entry row does with one operation
  typedef enum logic [1:0] {
    ROW_HOLD    = 2'd0,
    ROW_INSERT  = 2'd1,
    ROW_REMOVE  = 2'd2,
    ROW_REVERSE = 2'd3
  } row_act_e;

  // input word
  typedef struct packed {
    op_e                      operation;
    logic signed [DATA_W-1:0] value_in;
    logic [CNT_W-1:0]         index_in;
  } in_t;

  // result word
  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic [CNT_W-1:0]         index_out;
    logic [CNT_W-1:0]         occupancy;
    logic                     is_empty;
    status_e                  status;
  } out_t;

  // decoded operation, from the decoder to the row and the result register
  typedef struct packed {
    row_act_e         act;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count_d;
    logic             take;
    logic [CNT_W-1:0] index_out;
    status_e          status;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== sv/dles_ctrl.sv =====
// Operation decoder: checks fullness and range, picks the row action and position
`timescale 1ns / 1ps
`default_nettype none

module dles_ctrl import dles_pkg::*; (
  input  logic             valid_i,
  input  in_t              item_i,
  input  logic [CNT_W-1:0] count_i,
  output ctrl_t            ctrl_o
);

  logic full;
  logic empty;

  assign full  = (count_i == CNT_W'(CAPACITY));
  assign empty = (count_i == '0);

  // decode one operation against the current count
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.act       = ROW_HOLD;
    ctrl_o.count_d   = count_i;
    ctrl_o.status    = ST_OK;
    if (valid_i) begin
      unique case (item_i.operation)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            ctrl_o.status = ST_FULL;
          end else begin
            ctrl_o.act       = ROW_INSERT;
            ctrl_o.pos       = (item_i.operation == OP_PUSH_FRONT) ? '0 : count_i;
            ctrl_o.index_out = ctrl_o.pos;
            ctrl_o.count_d   = count_i + CNT_W'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            ctrl_o.status = ST_EMPTY;
          end else begin
            ctrl_o.act     = ROW_REMOVE;
            ctrl_o.pos     = (item_i.operation == OP_POP_FRONT) ? '0
                                                                : count_i - CNT_W'(1);
            ctrl_o.take    = 1'b1;
            ctrl_o.count_d = count_i - CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (full) begin
            ctrl_o.status = ST_FULL;
          end else if (item_i.index_in > count_i) begin
            ctrl_o.status = ST_RANGE;
          end else begin
            ctrl_o.act       = ROW_INSERT;
            ctrl_o.pos       = item_i.index_in;
            ctrl_o.index_out = item_i.index_in;
            ctrl_o.count_d   = count_i + CNT_W'(1);
          end
        end
        OP_ERASE, OP_READ: begin
          if (empty) begin
            ctrl_o.status = ST_EMPTY;
          end else if (item_i.index_in >= count_i) begin
            ctrl_o.status = ST_RANGE;
          end else if (item_i.operation == OP_ERASE) begin
            ctrl_o.act       = ROW_REMOVE;
            ctrl_o.pos       = item_i.index_in;
            ctrl_o.index_out = item_i.index_in;
            ctrl_o.count_d   = count_i - CNT_W'(1);
          end else begin
            ctrl_o.pos  = item_i.index_in;
            ctrl_o.take = 1'b1;
          end
        end
        OP_REVERSE: begin
          ctrl_o.act = ROW_REVERSE;
        end
        OP_CLEAR: begin
          ctrl_o.count_d = '0;
        end
        default: begin
          // unused codes leave the store alone and report ok
          ctrl_o.status = ST_OK;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dles_row.sv =====
// Entry row: index-ordered words that shift, take a new word or mirror
`timescale 1ns / 1ps
`default_nettype none

module dles_row import dles_pkg::*; (
  input  logic                     clk_i,
  input  ctrl_t                    ctrl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic signed [DATA_W-1:0] rd_o
);

  logic signed [DATA_W-1:0] entries_q [CAPACITY];
  logic signed [DATA_W-1:0] entries_d [CAPACITY];

  // word at the decoded position, for pops and reads
  assign rd_o = entries_q[ctrl_i.pos[IDX_W-1:0]];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    logic [CNT_W-1:0] mirror;
    logic             below_pos;
    logic             at_pos;
    logic             in_use;

    assign mirror    = count_i - CNT_W'(1) - CNT_W'(i);
    assign below_pos = (CNT_W'(i) < ctrl_i.pos);
    assign at_pos    = (CNT_W'(i) == ctrl_i.pos);
    assign in_use    = (CNT_W'(i) < count_i);

    // next value of this entry
    always_comb begin
      entries_d[i] = entries_q[i];
      unique case (ctrl_i.act)
        ROW_INSERT: begin
          if (at_pos) begin
            entries_d[i] = value_i;
          end else if (!below_pos) begin
            if (i > 0) begin
              entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
            end
          end
        end
        ROW_REMOVE: begin
          if (!below_pos && (i < CAPACITY - 1)) begin
            entries_d[i] = entries_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        ROW_REVERSE: begin
          if (in_use) begin
            entries_d[i] = entries_q[mirror[IDX_W-1:0]];
          end
        end
        ROW_HOLD: begin
          entries_d[i] = entries_q[i];
        end
        default: begin
          entries_d[i] = entries_q[i];
        end
      endcase
    end

    // storage, undefined until written
    always_ff @(posedge clk_i) begin
      entries_q[i] <= entries_d[i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/double_ended_list_store.sv =====
// Top level of the double-ended list store
`timescale 1ns / 1ps
`default_nettype none

// An ordered store of up to 16 signed 32-bit words. A word is taken at every
// clock edge where start is high (busy is always low), and its result appears
// on result_o with result_valid_o high for exactly one cycle, in the cycle after
// the edge that took it; the receiver cannot stall. Every operation, shifts
// and reverse included, finishes at the edge that takes it: the decoder and the
// per-entry multiplexers of the row sit between the input and the count,
// entry and result registers, so back-to-back words see each other's effects.
// Entry contents are undefined after reset; only the count and strobe are cleared.
module double_ended_list_store import dles_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic result_valid_o,
  output out_t result_o
);

  logic [CNT_W-1:0]         count_q;
  logic                     accept;
  ctrl_t                    ctrl;
  logic signed [DATA_W-1:0] rd_data;
  out_t                     res_d;
  out_t                     res_q;
  logic                     valid_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // decode against the current count
  dles_ctrl u_ctrl (
    .valid_i (accept),
    .item_i  (item_i),
    .count_i (count_q),
    .ctrl_o  (ctrl)
  );

  // entry row
  dles_row u_row (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .count_i (count_q),
    .value_i (item_i.value_in),
    .rd_o    (rd_data)
  );

  // result word
  always_comb begin
    res_d.value_out = ctrl.take ? rd_data : '0;
    res_d.index_out = ctrl.index_out;
    res_d.occupancy = ctrl.count_d;
    res_d.is_empty  = (ctrl.count_d == '0);
    res_d.status    = ctrl.status;
  end

  // count and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= ctrl.count_d;
      valid_q <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// ===== sv/dles_checker.sv =====
// Port checker for the double-ended list store and its bind
`timescale 1ns / 1ps
`default_nettype none

module dles_checker import dles_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic result_valid_o,
  input out_t result_o
);

  logic accept;

  assign accept = start && !busy;

  // every taken word gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("result strobe missing after a taken word");

  // no result without a taken word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result strobe without a taken word");

  // empty flag agrees with the occupancy
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.is_empty == (result_o.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  // occupancy never exceeds the capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.occupancy <= CNT_W'(CAPACITY)))
    else $error("occupancy above capacity");

  // clear always empties the store
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.operation == OP_CLEAR)) |=>
      (result_o.occupancy == '0) && (result_o.status == ST_OK))
    else $error("clear did not empty the store");

endmodule

bind double_ended_list_store dles_checker u_dles_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire

// ===== test/double_ended_list_store_tb.sv =====
// Testbench for the double-ended list store: directed and random words checked by a predictor
`timescale 1ns / 1ps
`default_nettype none

module double_ended_list_store_tb;
  import dles_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SHOWN_FAULTS    = 10;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned WORDS_PER_PHASE = 210;
  // highest operation code; everything above OP_CLEAR is unused
  localparam logic [3:0]  OP_TOP_CODE     = '1;

  // word waiting for the driver, with the idle odds of its phase
  typedef struct packed {
    in_t        word;
    logic [6:0] gap_pct;
    logic       drain_first;
  } pending_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  in_t  item_i = '0;
  logic busy;
  logic result_valid_o;
  out_t result_o;

  pending_t pending_words[$];
  out_t     due_results[$];
  pending_t head_word;
  out_t     want;

  // predicted contents of the store
  logic signed [DATA_W-1:0] held_words [CAPACITY];
  int unsigned held_count = 0;

  logic        word_taken   = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned words_total  = 0;
  int unsigned fault_count  = 0;
  int unsigned status_tally [4] = '{0, 0, 0, 0};

  double_ended_list_store dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial forever #2 clk_i = ~clk_i;

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= SHOWN_FAULTS) $display("%0t ns: %s", $time, what);
  endtask

  function automatic string show(input out_t r);
    return $sformatf("{value %0d, index %0d, occupancy %0d, empty %0b, status %s}",
                     r.value_out, r.index_out, r.occupancy, r.is_empty, r.status.name());
  endfunction

  // apply one word to the predicted store and return the result it should give
  function automatic out_t next_result(input in_t w);
    out_t r;
    int unsigned pos;
    int unsigned i;
    logic signed [DATA_W-1:0] tmp;
    r = '0;
    r.status = ST_OK;
    pos = w.index_in;
    case (w.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (w.operation == OP_PUSH_FRONT) pos = 0;
        if (w.operation == OP_PUSH_BACK) pos = held_count;
        // fullness wins over a bad index
        if (held_count >= CAPACITY) r.status = ST_FULL;
        else if (pos > held_count) r.status = ST_RANGE;
        else begin
          for (i = held_count; i > pos; i--) held_words[i] = held_words[i - 1];
          held_words[pos] = w.value_in;
          held_count++;
          r.index_out = CNT_W'(pos);
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_ERASE, OP_READ: begin
        if (w.operation == OP_POP_FRONT) pos = 0;
        if (w.operation == OP_POP_BACK) pos = held_count - 1;
        if (held_count == 0) r.status = ST_EMPTY;
        else if (pos >= held_count) r.status = ST_RANGE;
        else if (w.operation == OP_READ) r.value_out = held_words[pos];
        else begin
          // erase reports where the follower now sits, pops report the word
          if (w.operation == OP_ERASE) r.index_out = CNT_W'(pos);
          else r.value_out = held_words[pos];
          for (i = pos; i + 1 < held_count; i++) held_words[i] = held_words[i + 1];
          held_count--;
        end
      end
      OP_REVERSE: begin
        for (i = 0; i < held_count / 2; i++) begin
          tmp = held_words[i];
          held_words[i] = held_words[held_count - 1 - i];
          held_words[held_count - 1 - i] = tmp;
        end
      end
      OP_CLEAR: held_count = 0;
      default: ;
    endcase
    r.occupancy = CNT_W'(held_count);
    r.is_empty = (held_count == 0);
    return r;
  endfunction

  function automatic in_t make_word(input op_e op, input logic signed [DATA_W-1:0] val,
                                    input logic [CNT_W-1:0] idx);
    in_t w;
    w.operation = op;
    w.value_in = val;
    w.index_in = idx;
    return w;
  endfunction

  // random word, leaning toward growth or shrinkage so the store sweeps empty to full
  function automatic in_t rand_word(input bit grow);
    in_t w;
    int unsigned pick;
    int unsigned spread;
    pick = $urandom_range(99);
    spread = $urandom_range(9);
    w.value_in = $urandom;
    if ($urandom_range(15) == 0)
      w.value_in = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    if (spread == 0) w.index_in = CNT_W'($urandom);
    else if (spread < 5) w.index_in = CNT_W'($urandom_range(3));
    else w.index_in = CNT_W'($urandom_range(CAPACITY + 1));
    if (pick < (grow ? 65 : 25)) begin
      case ($urandom_range(2))
        0: w.operation = OP_PUSH_FRONT;
        1: w.operation = OP_PUSH_BACK;
        default: w.operation = OP_INSERT;
      endcase
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0: w.operation = OP_POP_FRONT;
        1: w.operation = OP_POP_BACK;
        default: w.operation = OP_ERASE;
      endcase
    end else if (pick < 93) w.operation = OP_READ;
    else if (pick < 97) w.operation = OP_REVERSE;
    else if (pick < 98) w.operation = OP_CLEAR;
    else w.operation = op_e'($urandom_range(OP_TOP_CODE, OP_CLEAR + 1));
    return w;
  endfunction

  task automatic queue_word(input in_t w, input int unsigned gap, input bit drain);
    pending_t p;
    p.word = w;
    p.gap_pct = 7'(gap);
    p.drain_first = drain;
    pending_words.push_back(p);
  endtask

  // driver: offers the next pending word at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) start <= 1'b0;
    else if (start && !word_taken) begin
      // word still on offer
    end else if (pending_words.size() == 0) start <= 1'b0;
    else begin
      head_word = pending_words[0];
      if ((head_word.drain_first && due_results.size() != 0) ||
          $urandom_range(99) < head_word.gap_pct) start <= 1'b0;
      else begin
        item_i <= head_word.word;
        start <= 1'b1;
        void'(pending_words.pop_front());
      end
    end
  end

  // monitor: check the result word first, then predict for the word taken now
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken <= start && !busy;
      if (result_valid_o) begin
        results_seen++;
        if (due_results.size() == 0)
          report_fault($sformatf("result with none due: %s", show(result_o)));
        else begin
          want = due_results.pop_front();
          if (result_o.value_out !== want.value_out || result_o.index_out !== want.index_out ||
              result_o.occupancy !== want.occupancy || result_o.is_empty !== want.is_empty ||
              result_o.status !== want.status)
            report_fault($sformatf("result mismatch: expected %s, got %s",
                                   show(want), show(result_o)));
        end
      end
      if (start && !busy) begin
        want = next_result(item_i);
        status_tally[want.status]++;
        due_results.push_back(want);
      end
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned run_left;
    int unsigned gap;
    bit grow;

    // empty store: taking operations report empty, reshaping does nothing
    queue_word(make_word(OP_POP_FRONT, 0, 0), 0, 1'b0);
    queue_word(make_word(OP_POP_BACK, 0, 0), 0, 1'b0);
    queue_word(make_word(OP_ERASE, 0, 0), 0, 1'b0);
    queue_word(make_word(OP_READ, 0, 0), 0, 1'b0);
    queue_word(make_word(OP_REVERSE, 0, 0), 0, 1'b0);
    queue_word(make_word(OP_CLEAR, 0, 0), 0, 1'b0);
    // insert past the end of an empty store, then right at its end
    queue_word(make_word(OP_INSERT, 123, 1), 0, 1'b0);
    queue_word(make_word(OP_INSERT, -5, 0), 0, 1'b0);
    queue_word(make_word(OP_REVERSE, 0, 0), 0, 1'b0);
    // extreme words at both ends, then bad indexes and a reverse
    queue_word(make_word(OP_PUSH_FRONT, 32'sh7fff_ffff, 0), 0, 1'b0);
    queue_word(make_word(OP_PUSH_BACK, 32'sh8000_0000, 0), 0, 1'b0);
    queue_word(make_word(OP_READ, 0, 3), 0, 1'b0);
    queue_word(make_word(OP_ERASE, 0, 5'd31), 0, 1'b0);
    queue_word(make_word(OP_REVERSE, 0, 0), 0, 1'b0);
    // erase the last word: follower index equals the new count
    queue_word(make_word(OP_ERASE, 0, 2), 0, 1'b0);
    // fill to capacity, then refused pushes and inserts
    for (n = 0; n < CAPACITY - 2; n++)
      queue_word(make_word(OP_PUSH_BACK, $urandom, 0), 0, 1'b0);
    queue_word(make_word(OP_PUSH_FRONT, 1, 0), 0, 1'b0);
    queue_word(make_word(OP_INSERT, 2, 5'd31), 0, 1'b0);
    queue_word(make_word(OP_READ, 0, CNT_W'(CAPACITY)), 0, 1'b0);
    queue_word(make_word(OP_POP_BACK, 0, 0), 0, 1'b0);
    queue_word(make_word(OP_INSERT, 3, CNT_W'(CAPACITY - 1)), 0, 1'b0);
    queue_word(make_word(op_e'(OP_TOP_CODE), -1, 5'd31), 0, 1'b0);
    queue_word(make_word(OP_CLEAR, 0, 0), 0, 1'b0);

    // random phases; the receiver cannot stall, so only the driver idles, and phases 0 and 2 run without idling
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1: gap = 88;
        3: gap = 35;
        default: gap = 0;
      endcase
      grow = 1'b1;
      run_left = $urandom_range(60, 20);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if (run_left == 0) begin
          grow = !grow;
          run_left = $urandom_range(60, 20);
        end
        run_left--;
        queue_word(rand_word(grow), gap, n == 0 || $urandom_range(99) == 0);
      end
    end
    words_total = pending_words.size();

    // reset is held from the start and released at a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < words_total) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (due_results.size() != 0)
      report_fault($sformatf("%0d results never arrived", due_results.size()));

    $display("ran %0d words through idle phases of 0, 88, 0 and 35 percent, with drain pauses",
             words_total);
    $display("outcomes: %0d ok, %0d full, %0d empty, %0d bad index; %0d faults",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_RANGE], fault_count);
    if (fault_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
